FILE: sv/tel_pkg.sv
package tel_pkg;

  localparam int TABLE_ENTRIES = 1024;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int POS_W         = $clog2(TABLE_ENTRIES + 1);

  localparam int TIME_W   = 32;
  localparam int EIDX_W   = 10;
  localparam int COUNT_W  = 11;
  localparam int OFFSET_W = 31;
  localparam int STEP_W   = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE    = 2'd2;

  localparam logic ACT_TICK  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHK,
    ST_FIN
  } tel_state_t;

endpackage

FILE: sv/tel_in_if.sv
interface tel_in_if;
  logic                              valid;
  logic                              ready;
  logic                              action;
  logic                              reset_level;
  logic [tel_pkg::EIDX_W-1:0]        entry_index;
  logic signed [tel_pkg::TIME_W-1:0] entry_time;

  modport source (output valid, action, reset_level, entry_index, entry_time, input ready);
  modport sink   (input valid, action, reset_level, entry_index, entry_time, output ready);
endinterface

FILE: sv/tel_out_if.sv
interface tel_out_if;
  logic valid;
  logic ready;
  logic trigger;

  modport source (output valid, trigger, input ready);
  modport sink   (input valid, trigger, output ready);
endinterface

FILE: sv/tel_cfg_if.sv
interface tel_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [tel_pkg::CFG_IDX_W-1:0]     index;
  logic [tel_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/timed_event_list_trigger.sv
// Channel  Dir  Payload                                          Transfer
// in_ch    in   action, reset_level, entry_index, entry_time     valid & ready
// out_ch   out  trigger                                          valid & ready
// cfg_ch   in   index, data                                      valid & ready
//
// Write item: accept, then result load. Tick: accept, then one compare per table
// entry: every passed entry skipped, plus the one that ends the scan unless the list
// runs out first (no compares when no entries remain), then result load.
// The single read port of the event table allows one compare per cycle.
// Reset (rst_n low, synchronous) clears control state; the event table is not cleared.
// A waiting result sits in the output register; the next item is accepted meanwhile,
// and its result is held back until that register is free.
module timed_event_list_trigger (
  input  logic      clk,
  input  logic      rst_n,
  tel_in_if.sink    in_ch,
  tel_out_if.source out_ch,
  tel_cfg_if.sink   cfg_ch
);
  import tel_pkg::*;

  // event table: one write port, one registered read port
  logic [TIME_W-1:0] mem [TABLE_ENTRIES];
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic [TIME_W-1:0] rd_data_r;

  // control and sequencing state
  tel_state_t                state_r, state_nxt;
  logic [POS_W-1:0]          pos_r, pos_nxt;
  logic signed [TIME_W-1:0]  time_r, time_nxt;
  logic                      last_level_r, last_level_nxt;
  logic                      fired_r, fired_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic                      out_trig_r, out_trig_nxt;

  // configuration registers
  logic [COUNT_W-1:0]          entry_count_r, entry_count_nxt;
  logic signed [OFFSET_W-1:0]  offset_r, offset_nxt;
  logic [STEP_W-1:0]           step_r, step_nxt;

  logic                      in_fire;
  logic                      cfg_fire;
  logic                      restart;
  logic [POS_W-1:0]          used;
  logic [31:0]               count_ext;
  logic [POS_W-1:0]          pos_base;
  logic [POS_W-1:0]          pos_inc;
  logic signed [TIME_W-1:0]  time_base;
  logic signed [TIME_W-1:0]  neg_offset;

  // counter advance with saturation; the counter never drops below the
  // most negative restart value, so only the positive side can overflow
  function automatic logic signed [TIME_W-1:0] advance(
    input logic signed [TIME_W-1:0] t,
    input logic [STEP_W-1:0]        s
  );
    logic signed [TIME_W:0] sum;
    sum = {t[TIME_W-1], t} + {{(TIME_W + 1 - STEP_W){1'b0}}, s};
    if (!sum[TIME_W] && sum[TIME_W-1]) begin
      return {1'b0, {(TIME_W - 1){1'b1}}};
    end
    return sum[TIME_W-1:0];
  endfunction

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign cfg_fire = cfg_ch.valid && cfg_ch.ready;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = (state_r == ST_IDLE);
  assign out_ch.valid   = out_valid_r;
  assign out_ch.trigger = out_trig_r;

  // entries in use, clipped to the table size
  assign count_ext = 32'(entry_count_r);
  assign used = (count_ext > 32'(TABLE_ENTRIES)) ? POS_W'(TABLE_ENTRIES) : POS_W'(count_ext);

  assign neg_offset = -{offset_r[OFFSET_W-1], offset_r};
  assign restart    = in_ch.reset_level && !last_level_r;
  assign pos_base   = restart ? '0 : pos_r;
  assign time_base  = restart ? neg_offset : time_r;
  assign pos_inc    = pos_r + POS_W'(1);

  assign mem_waddr = IDX_W'(in_ch.entry_index);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= in_ch.entry_time;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      pos_r         <= '0;
      time_r        <= '0;
      last_level_r  <= 1'b0;
      fired_r       <= 1'b0;
      out_valid_r   <= 1'b0;
      out_trig_r    <= 1'b0;
      entry_count_r <= '0;
      offset_r      <= '0;
      step_r        <= STEP_W'(1);
    end else begin
      state_r       <= state_nxt;
      pos_r         <= pos_nxt;
      time_r        <= time_nxt;
      last_level_r  <= last_level_nxt;
      fired_r       <= fired_nxt;
      out_valid_r   <= out_valid_nxt;
      out_trig_r    <= out_trig_nxt;
      entry_count_r <= entry_count_nxt;
      offset_r      <= offset_nxt;
      step_r        <= step_nxt;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    pos_nxt         = pos_r;
    time_nxt        = time_r;
    last_level_nxt  = last_level_r;
    fired_nxt       = fired_r;
    out_valid_nxt   = out_valid_r;
    out_trig_nxt    = out_trig_r;
    entry_count_nxt = entry_count_r;
    offset_nxt      = offset_r;
    step_nxt        = step_r;
    mem_we          = 1'b0;
    rd_en           = 1'b0;
    rd_addr         = pos_base[IDX_W-1:0];

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          fired_nxt = 1'b0;
          if (in_ch.action == ACT_WRITE) begin
            // out-of-range index: dropped
            mem_we    = (32'(in_ch.entry_index) < 32'(TABLE_ENTRIES));
            state_nxt = ST_FIN;
          end else begin
            last_level_nxt = in_ch.reset_level;
            pos_nxt        = pos_base;
            time_nxt       = time_base;
            if (pos_base < used) begin
              rd_en     = 1'b1;
              rd_addr   = pos_base[IDX_W-1:0];
              state_nxt = ST_CHK;
            end else begin
              time_nxt  = advance(time_base, step_r);
              state_nxt = ST_FIN;
            end
          end
        end
      end
      ST_CHK: begin
        // entry at pos_r is in rd_data_r; on a hit, fetch the next one
        if ($signed(rd_data_r) <= time_r) begin
          fired_nxt = 1'b1;
          pos_nxt   = pos_inc;
          if (pos_inc < used) begin
            rd_en   = 1'b1;
            rd_addr = pos_inc[IDX_W-1:0];
          end else begin
            time_nxt  = advance(time_r, step_r);
            state_nxt = ST_FIN;
          end
        end else begin
          time_nxt  = advance(time_r, step_r);
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_trig_nxt  = fired_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // register writes land only while idle
    if (cfg_fire) begin
      case (cfg_ch.index)
        REG_ENTRY_COUNT:  entry_count_nxt = cfg_ch.data[COUNT_W-1:0];
        REG_START_OFFSET: begin
          offset_nxt = cfg_ch.data[OFFSET_W-1:0];
          time_nxt   = -{cfg_ch.data[OFFSET_W-1], cfg_ch.data[OFFSET_W-1:0]};
        end
        REG_STEP_SIZE:    step_nxt = cfg_ch.data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_chk_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CHK |-> $past(rd_en))
    else $error("compare state without a table read");

  a_restart_pos: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_ch.action == ACT_TICK && restart |=> pos_r == '0)
    else $error("restart did not clear read position");

  a_write_no_fire: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_ch.action == ACT_WRITE |=> state_r == ST_FIN && !fired_r)
    else $error("write item marked as fired");

  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("result loaded outside finish state");
`endif

endmodule
